[sv/yqr_pkg.sv]
// ----------------------------------------------------------------------------
// yqr_pkg
// Shared widths, types, register indexes and reset values for the
// 4:2:0 quad to RGB24 converter.
// ----------------------------------------------------------------------------
package yqr_pkg;

   localparam int PixWidth    = 8;
   localparam int CoefWidth   = 18;
   localparam int DiffWidth   = PixWidth + 1;
   localparam int ProdWidth   = CoefWidth + 1 + DiffWidth;
   localparam int SumWidth    = ProdWidth + 2;
   localparam int FracBits    = 16;
   localparam int LaneCount   = 4;
   localparam int CsrIdxWidth = 3;
   localparam int StageCount  = 5;

   typedef logic signed [DiffWidth-1:0] diff_type;
   typedef logic signed [ProdWidth-1:0] prod_type;
   typedef logic signed [SumWidth-1:0]  sum_type;
   typedef logic [CoefWidth-1:0]        coef_type;
   typedef logic [PixWidth-1:0]         pix_type;

   typedef struct packed {
      pix_type red;
      pix_type green;
      pix_type blue;
   } rgb_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_LUMA_GAIN    = 3'd0,
      CSR_RED_FROM_V   = 3'd1,
      CSR_BLUE_FROM_U  = 3'd2,
      CSR_GREEN_FROM_U = 3'd3,
      CSR_GREEN_FROM_V = 3'd4
   } csr_index_type;

   localparam coef_type LumaGainReset   = 18'd76309;
   localparam coef_type RedFromVReset   = 18'd104597;
   localparam coef_type BlueFromUReset  = 18'd132201;
   localparam coef_type GreenFromUReset = 18'd25675;
   localparam coef_type GreenFromVReset = 18'd53279;

   localparam diff_type LumaOffset   = 9'sd16;
   localparam diff_type ChromaOffset = 9'sd128;

   // floor shift by FracBits, clamp to 0..255
   function automatic pix_type sat_byte(input sum_type s);
      pix_type res;
      if (s[SumWidth-1]) begin
         res = '0;
      end else if (|s[SumWidth-1:FracBits+PixWidth]) begin
         res = '1;
      end else begin
         res = s[FracBits+PixWidth-1:FracBits];
      end
      return res;
   endfunction

endpackage

[sv/yuv420_quad_to_rgb24.sv]
// A quad taken at a clock edge passes through five register stages before its
// result is on the rsp_ ports with rsp_valid high.
// Throughput: one quad per clock; busy stays low and start is taken every cycle.
// Rate is set by the multiply stage: eight 19x9 products in parallel each cycle.
// Reset (synchronous, active high) clears the pipeline valid bits and loads
// the five coefficients with their BT.601 defaults; the receiver cannot stall.
// ----------------------------------------------------------------------------
// yuv420_quad_to_rgb24
// Five-stage pipeline converting one YUV 4:2:0 quad to four RGB24 pixels
// with programmable Q16 coefficients.
// ----------------------------------------------------------------------------
module yuv420_quad_to_rgb24 (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [yqr_pkg::PixWidth-1:0]       req_luma_top_left,
   input  logic [yqr_pkg::PixWidth-1:0]       req_luma_top_right,
   input  logic [yqr_pkg::PixWidth-1:0]       req_luma_bottom_left,
   input  logic [yqr_pkg::PixWidth-1:0]       req_luma_bottom_right,
   input  logic [yqr_pkg::PixWidth-1:0]       req_chroma_blue,
   input  logic [yqr_pkg::PixWidth-1:0]       req_chroma_red,
   output logic                               rsp_valid,
   output logic [yqr_pkg::PixWidth-1:0]       rsp_red_top_left,
   output logic [yqr_pkg::PixWidth-1:0]       rsp_green_top_left,
   output logic [yqr_pkg::PixWidth-1:0]       rsp_blue_top_left,
   output logic [yqr_pkg::PixWidth-1:0]       rsp_red_top_right,
   output logic [yqr_pkg::PixWidth-1:0]       rsp_green_top_right,
   output logic [yqr_pkg::PixWidth-1:0]       rsp_blue_top_right,
   output logic [yqr_pkg::PixWidth-1:0]       rsp_red_bottom_left,
   output logic [yqr_pkg::PixWidth-1:0]       rsp_green_bottom_left,
   output logic [yqr_pkg::PixWidth-1:0]       rsp_blue_bottom_left,
   output logic [yqr_pkg::PixWidth-1:0]       rsp_red_bottom_right,
   output logic [yqr_pkg::PixWidth-1:0]       rsp_green_bottom_right,
   output logic [yqr_pkg::PixWidth-1:0]       rsp_blue_bottom_right,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [yqr_pkg::CsrIdxWidth-1:0]    csr_index,
   input  logic [yqr_pkg::CoefWidth-1:0]      csr_data
);
   import yqr_pkg::*;

   // coefficient registers
   coef_type gain_ff, gain_in;
   coef_type crv_ff, crv_in;
   coef_type cbu_ff, cbu_in;
   coef_type cgu_ff, cgu_in;
   coef_type cgv_ff, cgv_in;

   logic [StageCount-1:0] valid_ff, valid_in;

   pix_type luma [LaneCount];

   diff_type s1_luma_ff [LaneCount];
   diff_type s1_luma_in [LaneCount];
   diff_type s1_u_ff, s1_u_in;
   diff_type s1_v_ff, s1_v_in;

   prod_type s2_yk_ff [LaneCount];
   prod_type s2_yk_in [LaneCount];
   prod_type s2_r_ff, s2_r_in;
   prod_type s2_b_ff, s2_b_in;
   prod_type s2_gu_ff, s2_gu_in;
   prod_type s2_gv_ff, s2_gv_in;

   sum_type s3_yk_ff [LaneCount];
   sum_type s3_yk_in [LaneCount];
   sum_type s3_r_ff, s3_r_in;
   sum_type s3_b_ff, s3_b_in;
   sum_type s3_g_ff, s3_g_in;

   sum_type s4_red_ff [LaneCount];
   sum_type s4_red_in [LaneCount];
   sum_type s4_green_ff [LaneCount];
   sum_type s4_green_in [LaneCount];
   sum_type s4_blue_ff [LaneCount];
   sum_type s4_blue_in [LaneCount];

   rgb_type out_ff [LaneCount];
   rgb_type out_in [LaneCount];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // ---- configuration ----
   always_comb begin
      gain_in = gain_ff;
      crv_in  = crv_ff;
      cbu_in  = cbu_ff;
      cgu_in  = cgu_ff;
      cgv_in  = cgv_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LUMA_GAIN:    gain_in = csr_data;
            CSR_RED_FROM_V:   crv_in  = csr_data;
            CSR_BLUE_FROM_U:  cbu_in  = csr_data;
            CSR_GREEN_FROM_U: cgu_in  = csr_data;
            CSR_GREEN_FROM_V: cgv_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= LumaGainReset;
         crv_ff  <= RedFromVReset;
         cbu_ff  <= BlueFromUReset;
         cgu_ff  <= GreenFromUReset;
         cgv_ff  <= GreenFromVReset;
      end else begin
         gain_ff <= gain_in;
         crv_ff  <= crv_in;
         cbu_ff  <= cbu_in;
         cgu_ff  <= cgu_in;
         cgv_ff  <= cgv_in;
      end
   end

   // ---- valid chain ----
   assign valid_in = {valid_ff[StageCount-2:0], start && !busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign luma[0] = req_luma_top_left;
   assign luma[1] = req_luma_top_right;
   assign luma[2] = req_luma_bottom_left;
   assign luma[3] = req_luma_bottom_right;

   // ---- datapath ----
   always_comb begin
      // stage 1: remove offsets
      for (int k = 0; k < LaneCount; k++) begin
         s1_luma_in[k] = diff_type'({1'b0, luma[k]}) - LumaOffset;
      end
      s1_u_in = diff_type'({1'b0, req_chroma_blue}) - ChromaOffset;
      s1_v_in = diff_type'({1'b0, req_chroma_red}) - ChromaOffset;

      // stage 2: products
      for (int k = 0; k < LaneCount; k++) begin
         s2_yk_in[k] = prod_type'($signed({1'b0, gain_ff}) * s1_luma_ff[k]);
      end
      s2_r_in  = prod_type'($signed({1'b0, crv_ff}) * s1_v_ff);
      s2_b_in  = prod_type'($signed({1'b0, cbu_ff}) * s1_u_ff);
      s2_gu_in = prod_type'($signed({1'b0, cgu_ff}) * s1_u_ff);
      s2_gv_in = prod_type'($signed({1'b0, cgv_ff}) * s1_v_ff);

      // stage 3: green chroma term
      for (int k = 0; k < LaneCount; k++) begin
         s3_yk_in[k] = sum_type'(s2_yk_ff[k]);
      end
      s3_r_in = sum_type'(s2_r_ff);
      s3_b_in = sum_type'(s2_b_ff);
      s3_g_in = sum_type'(s2_gu_ff) + sum_type'(s2_gv_ff);

      // stage 4: per-pixel sums
      for (int k = 0; k < LaneCount; k++) begin
         s4_red_in[k]   = s3_yk_ff[k] + s3_r_ff;
         s4_green_in[k] = s3_yk_ff[k] - s3_g_ff;
         s4_blue_in[k]  = s3_yk_ff[k] + s3_b_ff;
      end

      // stage 5: shift and clamp
      for (int k = 0; k < LaneCount; k++) begin
         out_in[k].red   = sat_byte(s4_red_ff[k]);
         out_in[k].green = sat_byte(s4_green_ff[k]);
         out_in[k].blue  = sat_byte(s4_blue_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      s1_luma_ff  <= s1_luma_in;
      s1_u_ff     <= s1_u_in;
      s1_v_ff     <= s1_v_in;
      s2_yk_ff    <= s2_yk_in;
      s2_r_ff     <= s2_r_in;
      s2_b_ff     <= s2_b_in;
      s2_gu_ff    <= s2_gu_in;
      s2_gv_ff    <= s2_gv_in;
      s3_yk_ff    <= s3_yk_in;
      s3_r_ff     <= s3_r_in;
      s3_b_ff     <= s3_b_in;
      s3_g_ff     <= s3_g_in;
      s4_red_ff   <= s4_red_in;
      s4_green_ff <= s4_green_in;
      s4_blue_ff  <= s4_blue_in;
      out_ff      <= out_in;
   end

   assign rsp_valid              = valid_ff[StageCount-1];
   assign rsp_red_top_left       = out_ff[0].red;
   assign rsp_green_top_left     = out_ff[0].green;
   assign rsp_blue_top_left      = out_ff[0].blue;
   assign rsp_red_top_right      = out_ff[1].red;
   assign rsp_green_top_right    = out_ff[1].green;
   assign rsp_blue_top_right     = out_ff[1].blue;
   assign rsp_red_bottom_left    = out_ff[2].red;
   assign rsp_green_bottom_left  = out_ff[2].green;
   assign rsp_blue_bottom_left   = out_ff[2].blue;
   assign rsp_red_bottom_right   = out_ff[3].red;
   assign rsp_green_bottom_right = out_ff[3].green;
   assign rsp_blue_bottom_right  = out_ff[3].blue;

   // ---- assertions ----
   a_transfer_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##StageCount rsp_valid)
      else $error("accepted quad produced no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, StageCount))
      else $error("result without matching request");

   a_clamp_low: assert property (@(posedge clock) disable iff (reset)
      valid_ff[StageCount-2] && s4_green_ff[0][SumWidth-1] |=> rsp_green_top_left == '0)
      else $error("negative sum not clamped to zero");

   a_clamp_high: assert property (@(posedge clock) disable iff (reset)
      valid_ff[StageCount-2] && !s4_red_ff[3][SumWidth-1]
         && (|s4_red_ff[3][SumWidth-2:FracBits+PixWidth])
      |=> rsp_red_bottom_right == '1)
      else $error("overflowing sum not clamped to 255");

   a_csr_gain: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && csr_index == CSR_LUMA_GAIN |=> gain_ff == $past(csr_data))
      else $error("luma gain write lost");

endmodule

[tb/sv/yuv420_quad_to_rgb24_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// yuv420_quad_to_rgb24_test
// Drives YUV 4:2:0 quads into the converter across several coefficient sets
// and checks every RGB24 quad against a Q16 fixed-point predictor kept here.
// ----------------------------------------------------------------------------
module yuv420_quad_to_rgb24_test;
   import yqr_pkg::*;

   localparam int          MaxGap     = 14;
   localparam int unsigned CycleLimit = 300000;
   localparam coef_type    CoefMax    = '1;
   localparam int          CoefCount  = int'(CSR_GREEN_FROM_V) + 1;

   typedef struct packed {
      pix_type [LaneCount-1:0] luma;
      pix_type                 cb;
      pix_type                 cr;
   } quad_type;

   typedef rgb_type [LaneCount-1:0] quad_rgb_type;

   function automatic coef_type reset_coef(input int idx);
      coef_type value;
      case (idx)
         int'(CSR_LUMA_GAIN):    value = LumaGainReset;
         int'(CSR_RED_FROM_V):   value = RedFromVReset;
         int'(CSR_BLUE_FROM_U):  value = BlueFromUReset;
         int'(CSR_GREEN_FROM_U): value = GreenFromUReset;
         default:                value = GreenFromVReset;
      endcase
      return value;
   endfunction

   class pixel_ledger;
      coef_type     luma_gain;
      coef_type     red_from_v;
      coef_type     blue_from_u;
      coef_type     green_from_u;
      coef_type     green_from_v;
      quad_rgb_type pending[$];
      int unsigned  failures;

      function new();
         failures = 0;
         for (int i = 0; i < CoefCount; i++) begin
            set_coef(i[CsrIdxWidth-1:0], reset_coef(i));
         end
      endfunction

      // indexes past the last coefficient are dropped
      function void set_coef(input logic [CsrIdxWidth-1:0] idx, input coef_type value);
         case (idx)
            CSR_LUMA_GAIN:    luma_gain = value;
            CSR_RED_FROM_V:   red_from_v = value;
            CSR_BLUE_FROM_U:  blue_from_u = value;
            CSR_GREEN_FROM_U: green_from_u = value;
            CSR_GREEN_FROM_V: green_from_v = value;
            default: ;
         endcase
      endfunction

      function pix_type clamp_q16(input longint sum);
         longint whole;
         if (sum < 0) return '0;
         whole = sum >>> FracBits;
         if (whole > (1 << PixWidth) - 1) return '1;
         return whole[PixWidth-1:0];
      endfunction

      function quad_rgb_type convert_quad(input quad_type q);
         longint       u;
         longint       v;
         longint       r_term;
         longint       g_term;
         longint       b_term;
         longint       yk;
         quad_rgb_type px;
         u = longint'(q.cb) - longint'(ChromaOffset);
         v = longint'(q.cr) - longint'(ChromaOffset);
         r_term = longint'(red_from_v) * v;
         g_term = longint'(green_from_u) * u + longint'(green_from_v) * v;
         b_term = longint'(blue_from_u) * u;
         for (int k = 0; k < LaneCount; k++) begin
            yk = longint'(luma_gain) * (longint'(q.luma[k]) - longint'(LumaOffset));
            px[k].red   = clamp_q16(yk + r_term);
            px[k].green = clamp_q16(yk - g_term);
            px[k].blue  = clamp_q16(yk + b_term);
         end
         return px;
      endfunction

      function void note_quad(input quad_type q);
         pending.push_back(convert_quad(q));
      endfunction

      function string lane_name(input int k);
         case (k)
            0:       return "top_left";
            1:       return "top_right";
            2:       return "bottom_left";
            default: return "bottom_right";
         endcase
      endfunction

      function void compare_byte(input string field, input pix_type want, input pix_type got);
         if (want !== got) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            failures++;
         end
      endfunction

      function void check_pixels(input quad_rgb_type got);
         quad_rgb_type want;
         string        lane;
         if (pending.size() == 0) begin
            $error("rgb transfer with no quad outstanding");
            failures++;
            return;
         end
         want = pending.pop_front();
         for (int k = 0; k < LaneCount; k++) begin
            lane = lane_name(k);
            compare_byte({"red_", lane}, want[k].red, got[k].red);
            compare_byte({"green_", lane}, want[k].green, got[k].green);
            compare_byte({"blue_", lane}, want[k].blue, got[k].blue);
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   pix_type                req_luma_top_left = '0;
   pix_type                req_luma_top_right = '0;
   pix_type                req_luma_bottom_left = '0;
   pix_type                req_luma_bottom_right = '0;
   pix_type                req_chroma_blue = '0;
   pix_type                req_chroma_red = '0;
   logic                   rsp_valid;
   pix_type                rsp_red_top_left;
   pix_type                rsp_green_top_left;
   pix_type                rsp_blue_top_left;
   pix_type                rsp_red_top_right;
   pix_type                rsp_green_top_right;
   pix_type                rsp_blue_top_right;
   pix_type                rsp_red_bottom_left;
   pix_type                rsp_green_bottom_left;
   pix_type                rsp_blue_bottom_left;
   pix_type                rsp_red_bottom_right;
   pix_type                rsp_green_bottom_right;
   pix_type                rsp_blue_bottom_right;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   coef_type               csr_data = '0;

   int unsigned            cycle_count = 0;
   pixel_ledger            ledger = new();

   yuv420_quad_to_rgb24 dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_luma_top_left      (req_luma_top_left),
      .req_luma_top_right     (req_luma_top_right),
      .req_luma_bottom_left   (req_luma_bottom_left),
      .req_luma_bottom_right  (req_luma_bottom_right),
      .req_chroma_blue        (req_chroma_blue),
      .req_chroma_red         (req_chroma_red),
      .rsp_valid              (rsp_valid),
      .rsp_red_top_left       (rsp_red_top_left),
      .rsp_green_top_left     (rsp_green_top_left),
      .rsp_blue_top_left      (rsp_blue_top_left),
      .rsp_red_top_right      (rsp_red_top_right),
      .rsp_green_top_right    (rsp_green_top_right),
      .rsp_blue_top_right     (rsp_blue_top_right),
      .rsp_red_bottom_left    (rsp_red_bottom_left),
      .rsp_green_bottom_left  (rsp_green_bottom_left),
      .rsp_blue_bottom_left   (rsp_blue_bottom_left),
      .rsp_red_bottom_right   (rsp_red_bottom_right),
      .rsp_green_bottom_right (rsp_green_bottom_right),
      .rsp_blue_bottom_right  (rsp_blue_bottom_right),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_data               (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("yuv420_quad_to_rgb24 regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         ledger.check_pixels({
            rsp_red_bottom_right, rsp_green_bottom_right, rsp_blue_bottom_right,
            rsp_red_bottom_left,  rsp_green_bottom_left,  rsp_blue_bottom_left,
            rsp_red_top_right,    rsp_green_top_right,    rsp_blue_top_right,
            rsp_red_top_left,     rsp_green_top_left,     rsp_blue_top_left});
      end
   end

   function automatic quad_type make_quad(input pix_type tl, input pix_type tr,
                                          input pix_type bl, input pix_type br,
                                          input pix_type cb, input pix_type cr);
      quad_type q;
      q.luma[0] = tl;
      q.luma[1] = tr;
      q.luma[2] = bl;
      q.luma[3] = br;
      q.cb      = cb;
      q.cr      = cr;
      return q;
   endfunction

   // biased toward the rails and the video-range offsets
   function automatic pix_type pick_sample();
      pix_type s;
      case ($urandom_range(0, 9))
         0:       s = '0;
         1:       s = '1;
         2:       s = pix_type'($urandom_range(12, 20));
         3:       s = pix_type'($urandom_range(124, 132));
         4:       s = pix_type'($urandom_range(230, 240));
         default: s = pix_type'($urandom_range(0, 255));
      endcase
      return s;
   endfunction

   function automatic quad_type random_quad();
      return make_quad(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                       pick_sample(), pick_sample());
   endfunction

   task automatic send_quad(input quad_type q, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start                 <= 1'b1;
      req_luma_top_left     <= q.luma[0];
      req_luma_top_right    <= q.luma[1];
      req_luma_bottom_left  <= q.luma[2];
      req_luma_bottom_right <= q.luma[3];
      req_chroma_blue       <= q.cb;
      req_chroma_red        <= q.cr;
      @(posedge clock);
      while (busy) @(posedge clock);
      ledger.note_quad(q);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (ledger.pending.size() != 0) @(posedge clock);
   endtask

   task automatic csr_transfer(input logic [CsrIdxWidth-1:0] idx, input coef_type value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      ledger.set_coef(idx, value);
   endtask

   // one write to an unused index rides along with every coefficient load
   task automatic write_coefs(input coef_type plan [CoefCount]);
      logic [CsrIdxWidth-1:0] spare;
      spare = CsrIdxWidth'($urandom_range(CoefCount, (1 << CsrIdxWidth) - 1));
      csr_transfer(spare, coef_type'($urandom()));
      for (int i = 0; i < CoefCount; i++) begin
         csr_transfer(i[CsrIdxWidth-1:0], plan[i]);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      quad_type corner_cases[$];
      coef_type plan [CoefCount];
      int       phase_items [6];
      coef_type rc;
      int       gap;

      phase_items = '{60, 60, 180, 80, 140, 80};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      corner_cases.push_back(make_quad(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
      corner_cases.push_back(make_quad(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
      corner_cases.push_back(make_quad(8'd16, 8'd16, 8'd16, 8'd16, 8'd128, 8'd128));
      corner_cases.push_back(make_quad(8'd235, 8'd235, 8'd235, 8'd235, 8'd128, 8'd128));
      corner_cases.push_back(make_quad(8'd0, 8'd255, 8'd16, 8'd235, 8'd128, 8'd128));
      corner_cases.push_back(make_quad(8'd128, 8'd128, 8'd128, 8'd128, 8'd0, 8'd0));
      corner_cases.push_back(make_quad(8'd128, 8'd128, 8'd128, 8'd128, 8'd255, 8'd255));
      corner_cases.push_back(make_quad(8'd128, 8'd128, 8'd128, 8'd128, 8'd0, 8'd255));
      corner_cases.push_back(make_quad(8'd128, 8'd128, 8'd128, 8'd128, 8'd255, 8'd0));
      corner_cases.push_back(make_quad(8'd15, 8'd17, 8'd16, 8'd16, 8'd127, 8'd129));
      corner_cases.push_back(make_quad(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255));
      corner_cases.push_back(make_quad(8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0));
      corner_cases.push_back(make_quad(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55));
      corner_cases.push_back(make_quad(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA));
      corner_cases.push_back(make_quad(8'd81, 8'd145, 8'd41, 8'd210, 8'd90, 8'd240));
      foreach (corner_cases[n]) send_quad(corner_cases[n], $urandom_range(0, MaxGap));

      for (int phase = 0; phase < 6; phase++) begin
         wait_drained();
         for (int i = 0; i < CoefCount; i++) begin
            rc = reset_coef(i);
            case (phase)
               0: plan[i] = '0;
               1: plan[i] = CoefMax;
               2: plan[i] = rc;
               3: plan[i] = coef_type'($urandom_range(0, CoefMax));
               4: plan[i] = coef_type'($urandom_range(rc / 2, rc + rc / 2));
               default: begin
                  case ($urandom_range(0, 2))
                     0:       plan[i] = '0;
                     1:       plan[i] = CoefMax;
                     default: plan[i] = coef_type'($urandom_range(0, CoefMax));
                  endcase
               end
            endcase
         end
         write_coefs(plan);

         // back-to-back stretches alternate with random spacing
         for (int n = 0; n < phase_items[phase]; n++) begin
            gap = (n % 40 < 12) ? 0 : $urandom_range(0, MaxGap);
            send_quad(random_quad(), gap);
            if (n == phase_items[phase] / 2) wait_drained();
         end
      end

      wait_drained();
      repeat (StageCount + 3) @(posedge clock);
      if (ledger.failures == 0 && ledger.pending.size() == 0) begin
         $display("yuv420_quad_to_rgb24 regression: pass");
      end else begin
         $display("yuv420_quad_to_rgb24 regression: fail");
      end
      $finish;
   end

endmodule

[yuv420_quad_to_rgb24.f]
sv/yqr_pkg.sv
sv/yuv420_quad_to_rgb24.sv
tb/sv/yuv420_quad_to_rgb24_test.sv
